// ----- sv/vna_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vna_pkg
// Shared widths, opcodes and controller/datapath handshake types.
// ---------------------------------------------------------------------------
package vna_pkg;

    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int CMP_W            = 17;   // holds any depth up to 65536

    localparam int IDX_W   = 12;
    localparam int POS_W   = 24;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;
    localparam int NRM_W   = 16;
    localparam int DIFF_W  = 25;
    localparam int PROD_W  = 50;
    localparam int CROSS_W = 51;
    localparam int MAG_W   = 50;
    localparam int RED_W   = 30;            // magnitude width after reduction
    localparam int SQ_W    = 2 * RED_W;
    localparam int SQSUM_W = 62;
    localparam int LEN_W   = 32;
    localparam int FRAC_W  = 15;
    localparam int QUO_W   = 17;
    localparam int NUM_W   = RED_W + FRAC_W + 1;

    localparam int IN_TDATA_W  = 120;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_USED_W  = 3 * NRM_W + 1 + CNT_W;

    localparam int STEP_W = 5;
    localparam int SEL_W  = 2;

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(6);
    localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(3);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(30);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
    localparam logic [SEL_W-1:0]  SEL_LAST  = SEL_W'(2);

    localparam logic [NRM_W-1:0] NRM_MAX = NRM_W'(32767);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(255);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FACE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLEAR, DP_LOAD, DP_WRVTX, DP_PRD, DP_PCAP, DP_DIFF,
        DP_MUL, DP_MAG, DP_SHIFT, DP_SQ, DP_SQRT, DP_DIVI, DP_DIVS,
        DP_DIVE, DP_ARD, DP_AWR, DP_SRD, DP_QCAP, DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [SEL_W-1:0]  sel;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    vi_bad;
        logic    face_bad;
        logic    clr_last;
        logic    is_zero;
        logic    too_big;
    } dp_sts_t;

endpackage

// ----- sv/vertex_normal_accumulator_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertex_normal_accumulator_unit
// Face normals and averaged vertex normals over a vertex store.
// ---------------------------------------------------------------------------
// Usage:
//  - s_axis carries commands: tuser is the opcode (write vertex, add face,
//    query vertex), tdata the index, position and corner fields.
//  - m_axis carries results: tuser is the kind (face / vertex normal),
//    tdata the Q1.15 normal, degenerate flag and share count.
//  - One command in flight at a time. Vertex write: no result. Face: runs
//    through the serial cross product (one multiplier, 7 steps), a
//    one-bit-per-cycle reduction shift (up to 19), a 31-step isqrt, three
//    17-step divisions on one divider and three read-modify-writes; a
//    zero-area face skips the normalizer. Query: through the same
//    normalizer, which a zero sum skips; an index past the store goes
//    straight to the result. Unused opcode: no result.
//  - A finished result sits in the output register; the next beat is taken
//    while it waits. If m_axis stalls, the following result holds in the
//    sequencer until the register frees.
//  - After reset the sum/count store is swept, one entry per cycle, with
//    s_axis_tready low.
// ---------------------------------------------------------------------------
module vertex_normal_accumulator_unit #(
    parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [vna_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [vna_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // normal_x, normal_y, normal_z, degenerate, share_count, zero pad
    output logic [vna_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // result_kind
    output logic                             m_axis_tuser
);
    import vna_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    vna_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    vna_datapath #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

endmodule

// ----- sv/vna_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vna_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/vna_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vna_datapath
// Stores, cross product, normalizer (shift, isqrt, divider), accumulate.
// ---------------------------------------------------------------------------
module vna_datapath #(
    parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vna_pkg::dp_cmd_t                 cmd,
    output vna_pkg::dp_sts_t                 sts,
    input  logic [vna_pkg::IN_TDATA_W-1:0]   in_tdata,
    input  logic [vna_pkg::IN_TUSER_W-1:0]   in_tuser,
    output logic [vna_pkg::OUT_TDATA_W-1:0]  out_tdata,
    output logic                             out_tuser
);
    import vna_pkg::*;

    localparam int AW    = $clog2(VERTEX_DEPTH);
    localparam int ACC_W = 3 * SUM_W + CNT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(VERTEX_DEPTH);

    // captured beat
    opcode_t                 opcode_reg;
    logic [IDX_W-1:0]        vi_reg;
    logic [3*POS_W-1:0]      pos_reg;
    logic [2:0][IDX_W-1:0]   corner_reg;

    logic [2:0][2:0][POS_W-1:0] p_reg;
    logic signed [DIFF_W-1:0]   b_reg [3];
    logic signed [DIFF_W-1:0]   a_reg [3];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [CROSS_W-1:0]  c_reg [3];
    logic [2:0]                 neg_reg;
    logic [MAG_W-1:0]           mag_reg [3];
    logic                       zero_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [SQSUM_W-1:0]         sum_reg;
    logic [SQSUM_W-1:0]         rs_reg;
    logic [SQSUM_W-1:0]         root_reg;
    logic [SQSUM_W-1:0]         bit_reg;
    logic [LEN_W-1:0]           rem_reg;
    logic [QUO_W-1:0]           num_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic signed [NRM_W-1:0]    q_reg [3];
    logic [CNT_W-1:0]           cnt_q_reg;
    logic [AW-1:0]              clr_addr_reg;

    logic [3*POS_W-1:0] pos_rdata;
    logic [ACC_W-1:0]   acc_rdata;
    logic               acc_we;
    logic [AW-1:0]      acc_waddr;
    logic [AW-1:0]      acc_raddr;
    logic [ACC_W-1:0]   acc_wdata;
    logic [ACC_W-1:0]   acc_upd;

    logic signed [DIFF_W-1:0] mul_x;
    logic signed [DIFF_W-1:0] mul_y;
    logic signed [PROD_W-1:0] mul_res;
    logic [2:0]               acc_idx;
    logic [RED_W-1:0]         sq_m;
    logic [SQSUM_W-1:0]       s_in;
    logic [SQSUM_W-1:0]       root_in;
    logic [SQSUM_W-1:0]       bit_in;
    logic [SQSUM_W-1:0]       trial;
    logic [LEN_W-1:0]         len;
    logic [NUM_W-1:0]         num_full;
    logic [LEN_W:0]           r2;
    logic [QUO_W-1:0]         q_neg;
    logic                     e_kind;
    logic                     e_bad;
    logic                     e_degen;
    logic [CNT_W-1:0]         e_cnt;
    logic [MAG_W-1:0]         mag_or;

    // status
    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];
    always_comb
    begin
        sts.opcode   = opcode_reg;
        sts.vi_bad   = CMP_W'(vi_reg) >= DEPTH_C;
        sts.face_bad = (CMP_W'(corner_reg[0]) >= DEPTH_C) ||
                       (CMP_W'(corner_reg[1]) >= DEPTH_C) ||
                       (CMP_W'(corner_reg[2]) >= DEPTH_C);
        sts.clr_last = clr_addr_reg == AW'(VERTEX_DEPTH - 1);
        sts.is_zero  = zero_reg;
        sts.too_big  = |mag_or[MAG_W-1:RED_W];
    end

    // stores
    vna_ram #(.WIDTH(3 * POS_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (cmd.op == DP_WRVTX),
        .waddr (AW'(vi_reg)),
        .wdata (pos_reg),
        .raddr (AW'(corner_reg[cmd.sel])),
        .rdata (pos_rdata)
    );

    // accumulate: saturating sum plus saturating count
    always_comb
    begin
        logic signed [SUM_W:0] t;
        for (int j = 0; j < 3; j++)
        begin
            t = (SUM_W + 1)'($signed(acc_rdata[j*SUM_W +: SUM_W])) +
                (SUM_W + 1)'(q_reg[j]);
            if (t[SUM_W] != t[SUM_W-1])
            begin
                acc_upd[j*SUM_W +: SUM_W] = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                     : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                acc_upd[j*SUM_W +: SUM_W] = t[SUM_W-1:0];
            end
        end
        acc_upd[3*SUM_W +: CNT_W] = (acc_rdata[3*SUM_W +: CNT_W] == CNT_MAX) ? CNT_MAX
                                  : acc_rdata[3*SUM_W +: CNT_W] + CNT_W'(1);
    end

    always_comb
    begin
        acc_we    = 1'b0;
        acc_waddr = AW'(corner_reg[cmd.sel]);
        acc_wdata = acc_upd;
        case (cmd.op)
            DP_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_addr_reg;
                acc_wdata = '0;
            end
            DP_WRVTX:
            begin
                acc_we    = 1'b1;
                acc_waddr = AW'(vi_reg);
                acc_wdata = '0;
            end
            DP_AWR:
            begin
                acc_we = 1'b1;
            end
            default:
            begin
                acc_we = 1'b0;
            end
        endcase
    end

    assign acc_raddr = (cmd.op == DP_SRD) ? AW'(vi_reg) : AW'(corner_reg[cmd.sel]);

    vna_ram #(.WIDTH(ACC_W), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // cross product operand schedule
    always_comb
    begin
        case (cmd.step)
            STEP_W'(0): begin mul_x = b_reg[1]; mul_y = a_reg[2]; end
            STEP_W'(1): begin mul_x = b_reg[2]; mul_y = a_reg[1]; end
            STEP_W'(2): begin mul_x = b_reg[2]; mul_y = a_reg[0]; end
            STEP_W'(3): begin mul_x = b_reg[0]; mul_y = a_reg[2]; end
            STEP_W'(4): begin mul_x = b_reg[0]; mul_y = a_reg[1]; end
            default:    begin mul_x = b_reg[1]; mul_y = a_reg[0]; end
        endcase
        mul_res = PROD_W'(mul_x) * PROD_W'(mul_y);
        acc_idx = 3'(cmd.step - STEP_W'(1));
    end

    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:    sq_m = mag_reg[0][RED_W-1:0];
            2'd1:    sq_m = mag_reg[1][RED_W-1:0];
            default: sq_m = mag_reg[2][RED_W-1:0];
        endcase
    end

    // digit-by-digit isqrt, one bit pair per step
    always_comb
    begin
        s_in    = (cmd.step == '0) ? sum_reg : rs_reg;
        root_in = (cmd.step == '0) ? '0 : root_reg;
        bit_in  = (cmd.step == '0) ? (SQSUM_W'(1) << (SQSUM_W - 2)) : bit_reg;
        trial   = root_in + bit_in;
    end

    assign len      = root_reg[LEN_W-1:0];
    assign num_full = NUM_W'({mag_reg[cmd.sel][RED_W-1:0], {FRAC_W{1'b0}}}) +
                      NUM_W'(len >> 1);
    assign r2       = {rem_reg, num_reg[QUO_W-1]};
    assign q_neg    = QUO_W'(0) - quo_reg;

    // result fields
    always_comb
    begin
        e_kind  = opcode_reg == OP_QUERY;
        e_bad   = e_kind && sts.vi_bad;
        e_degen = e_bad || zero_reg || (e_kind && (cnt_q_reg == '0));
        e_cnt   = (e_kind && !e_bad) ? cnt_q_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.op == DP_CLEAR)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                opcode_reg    <= opcode_t'(in_tuser);
                vi_reg        <= in_tdata[IDX_W-1:0];
                pos_reg       <= in_tdata[IDX_W +: 3*POS_W];
                corner_reg[0] <= in_tdata[IDX_W + 3*POS_W +: IDX_W];
                corner_reg[1] <= in_tdata[2*IDX_W + 3*POS_W +: IDX_W];
                corner_reg[2] <= in_tdata[3*IDX_W + 3*POS_W +: IDX_W];
            end
            DP_PCAP:
            begin
                p_reg[cmd.sel] <= pos_rdata;
            end
            DP_DIFF:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    b_reg[j] <= DIFF_W'($signed(p_reg[1][j])) - DIFF_W'($signed(p_reg[0][j]));
                    a_reg[j] <= DIFF_W'($signed(p_reg[2][j])) - DIFF_W'($signed(p_reg[0][j]));
                end
            end
            DP_MUL:
            begin
                prod_reg <= mul_res;
                if (cmd.step != '0)
                begin
                    if (!acc_idx[0])
                    begin
                        c_reg[acc_idx[2:1]] <= CROSS_W'(prod_reg);
                    end
                    else
                    begin
                        c_reg[acc_idx[2:1]] <= c_reg[acc_idx[2:1]] - CROSS_W'(prod_reg);
                    end
                end
            end
            DP_QCAP:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    c_reg[j] <= CROSS_W'($signed(acc_rdata[j*SUM_W +: SUM_W]));
                end
                cnt_q_reg <= acc_rdata[3*SUM_W +: CNT_W];
            end
            DP_MAG:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    neg_reg[j] <= c_reg[j] < 0;
                    mag_reg[j] <= MAG_W'((c_reg[j] < 0) ? -c_reg[j] : c_reg[j]);
                    q_reg[j]   <= '0;
                end
                zero_reg <= (c_reg[0] == 0) && (c_reg[1] == 0) && (c_reg[2] == 0);
            end
            DP_SHIFT:
            begin
                if (sts.too_big)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        mag_reg[j] <= mag_reg[j] >> 1;
                    end
                end
            end
            DP_SQ:
            begin
                sq_reg <= sq_m * sq_m;
                if (cmd.step == STEP_W'(1))
                begin
                    sum_reg <= SQSUM_W'(sq_reg);
                end
                else if (cmd.step != '0)
                begin
                    sum_reg <= sum_reg + SQSUM_W'(sq_reg);
                end
            end
            DP_SQRT:
            begin
                if (s_in >= trial)
                begin
                    rs_reg   <= s_in - trial;
                    root_reg <= (root_in >> 1) + bit_in;
                end
                else
                begin
                    rs_reg   <= s_in;
                    root_reg <= root_in >> 1;
                end
                bit_reg <= bit_in >> 2;
            end
            DP_DIVI:
            begin
                rem_reg <= LEN_W'(num_full[NUM_W-1:QUO_W]);
                num_reg <= num_full[QUO_W-1:0];
                quo_reg <= '0;
            end
            DP_DIVS:
            begin
                if (r2 >= {1'b0, len})
                begin
                    rem_reg <= LEN_W'(r2 - {1'b0, len});
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= LEN_W'(r2);
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                num_reg <= {num_reg[QUO_W-2:0], 1'b0};
            end
            DP_DIVE:
            begin
                if (neg_reg[cmd.sel])
                begin
                    q_reg[cmd.sel] <= q_neg[NRM_W-1:0];
                end
                else if (quo_reg > QUO_W'(NRM_MAX))
                begin
                    q_reg[cmd.sel] <= NRM_MAX;
                end
                else
                begin
                    q_reg[cmd.sel] <= quo_reg[NRM_W-1:0];
                end
            end
            DP_EMIT:
            begin
                out_tuser <= e_kind;
                out_tdata <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, e_cnt, e_degen,
                              e_degen ? {(3*NRM_W){1'b0}} : {q_reg[2], q_reg[1], q_reg[0]}};
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

endmodule

// ----- sv/vna_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vna_ctrl
// Sequencer: clearing pass, opcode decode, step counting, output beat.
// ---------------------------------------------------------------------------
module vna_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output vna_pkg::dp_cmd_t cmd,
    input  vna_pkg::dp_sts_t sts
);
    import vna_pkg::*;

    typedef enum logic [19:0] {
        S_CLEAR  = 20'h00001,
        S_IDLE   = 20'h00002,
        S_DECODE = 20'h00004,
        S_WRV    = 20'h00008,
        S_PRD    = 20'h00010,
        S_PCAP   = 20'h00020,
        S_DIFF   = 20'h00040,
        S_MUL    = 20'h00080,
        S_MAG    = 20'h00100,
        S_SHIFT  = 20'h00200,
        S_SQ     = 20'h00400,
        S_SQRT   = 20'h00800,
        S_DIVI   = 20'h01000,
        S_DIVS   = 20'h02000,
        S_DIVE   = 20'h04000,
        S_ARD    = 20'h08000,
        S_AWR    = 20'h10000,
        S_SRD    = 20'h20000,
        S_QCAP   = 20'h40000,
        S_DONE   = 20'h80000
    } state_t;

    state_t            state_reg, state_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = DP_NOP;
        cmd.sel        = sel_reg;
        cmd.step       = step_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                sel_next  = '0;
                step_next = '0;
                case (sts.opcode)
                    OP_WRITE: state_next = sts.vi_bad ? S_IDLE : S_WRV;
                    OP_FACE:  state_next = sts.face_bad ? S_IDLE : S_PRD;
                    OP_QUERY: state_next = sts.vi_bad ? S_DONE : S_SRD;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_WRV:
            begin
                cmd.op     = DP_WRVTX;
                state_next = S_IDLE;
            end
            S_PRD:
            begin
                cmd.op     = DP_PRD;
                state_next = S_PCAP;
            end
            S_PCAP:
            begin
                cmd.op = DP_PCAP;
                if (sel_reg == SEL_LAST)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    sel_next   = sel_reg + SEL_W'(1);
                    state_next = S_PRD;
                end
            end
            S_DIFF:
            begin
                cmd.op     = DP_DIFF;
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = DP_MUL;
                if (step_reg == MUL_LAST)
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_MAG:
            begin
                cmd.op     = DP_MAG;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                sel_next  = '0;
                step_next = '0;
                if (sts.is_zero)
                begin
                    state_next = (sts.opcode == OP_FACE) ? S_ARD : S_DONE;
                end
                else if (sts.too_big)
                begin
                    cmd.op = DP_SHIFT;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op = DP_SQ;
                if (step_reg == SQ_LAST)
                begin
                    step_next  = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_SQRT:
            begin
                cmd.op = DP_SQRT;
                if (step_reg == SQRT_LAST)
                begin
                    sel_next   = '0;
                    state_next = S_DIVI;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DIVI:
            begin
                cmd.op     = DP_DIVI;
                step_next  = '0;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.op = DP_DIVS;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_DIVE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DIVE:
            begin
                cmd.op = DP_DIVE;
                if (sel_reg == SEL_LAST)
                begin
                    sel_next   = '0;
                    state_next = (sts.opcode == OP_FACE) ? S_ARD : S_DONE;
                end
                else
                begin
                    sel_next   = sel_reg + SEL_W'(1);
                    state_next = S_DIVI;
                end
            end
            S_ARD:
            begin
                cmd.op     = DP_ARD;
                state_next = S_AWR;
            end
            S_AWR:
            begin
                cmd.op = DP_AWR;
                if (sel_reg == SEL_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    sel_next   = sel_reg + SEL_W'(1);
                    state_next = S_ARD;
                end
            end
            S_SRD:
            begin
                cmd.op     = DP_SRD;
                state_next = S_QCAP;
            end
            S_QCAP:
            begin
                cmd.op     = DP_QCAP;
                state_next = S_MAG;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = DP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sel_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/vna_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vna_checker
// Port-level checks on the normal accumulator, bound to the top level.
// ---------------------------------------------------------------------------
module vna_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [vna_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);
    import vna_pkg::*;

    // one command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    a_face_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[3*NRM_W+1 +: CNT_W] == '0)
        else $error("face result with nonzero share count");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3*NRM_W] |-> m_axis_tdata[3*NRM_W-1:0] == '0)
        else $error("degenerate result with nonzero normal");

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
